@@ design/single_server_queue_sim_step_core_macros.svh @@
// Assertion macros shared by the queue simulation step core.
`ifndef SINGLE_SERVER_QUEUE_SIM_STEP_CORE_MACROS_SVH
`define SINGLE_SERVER_QUEUE_SIM_STEP_CORE_MACROS_SVH

// same-cycle implication
`define SSQ_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SSQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/ssq_pkg.sv @@
// Types, constants and table functions of the queue simulation step core.
package ssq_pkg;

  localparam int ARR_W  = 10;
  localparam int SVC_DW = 7;
  localparam int GAP_W  = 4;
  localparam int SVC_W  = 3;
  localparam int TIME_W = 20;
  localparam int SUM_W  = 34;

  localparam int ARR_BIN       = 125;
  localparam int ARR_DIGIT_MAX = 999;
  localparam int GAP_MAX       = 8;

  localparam logic [SVC_DW-1:0] SVC_B1 = SVC_DW'(10);
  localparam logic [SVC_DW-1:0] SVC_B2 = SVC_DW'(30);
  localparam logic [SVC_DW-1:0] SVC_B3 = SVC_DW'(60);
  localparam logic [SVC_DW-1:0] SVC_B4 = SVC_DW'(85);
  localparam logic [SVC_DW-1:0] SVC_B5 = SVC_DW'(95);
  localparam logic [SVC_DW-1:0] SVC_B6 = SVC_DW'(99);

  localparam logic [TIME_W-1:0] TIME_MAX = '1;
  localparam logic [SUM_W-1:0]  SUM_MAX  = '1;

  typedef struct packed {
    logic [ARR_W-1:0]  arrival_digit;
    logic [SVC_DW-1:0] service_digit;
  } ssq_cust_t;

  typedef struct packed {
    logic [GAP_W-1:0] gap;
    logic [SVC_W-1:0] svc;
  } ssq_work_t;

  typedef struct packed {
    logic [GAP_W-1:0]  interarrival;
    logic [SVC_W-1:0]  service_len;
    logic [TIME_W-1:0] arrive_at;
    logic [TIME_W-1:0] begin_at;
    logic [TIME_W-1:0] queue_wait;
    logic [TIME_W-1:0] end_at;
    logic [TIME_W-1:0] in_system;
    logic [TIME_W-1:0] server_idle;
  } ssq_times_t;

  typedef struct packed {
    logic [GAP_W-1:0]  interarrival;
    logic [SVC_W-1:0]  service_len;
    logic [TIME_W-1:0] arrive_at;
    logic [TIME_W-1:0] begin_at;
    logic [TIME_W-1:0] queue_wait;
    logic [TIME_W-1:0] end_at;
    logic [TIME_W-1:0] in_system;
    logic [TIME_W-1:0] server_idle;
    logic [SUM_W-1:0]  sum_service;
    logic [SUM_W-1:0]  sum_wait;
    logic [SUM_W-1:0]  sum_in_system;
    logic [SUM_W-1:0]  sum_idle;
  } ssq_rec_t;

  function automatic logic [GAP_W-1:0] arrival_gap(input logic [ARR_W-1:0] d);
    logic [GAP_W-1:0] g;
    g = '0;
    if (d != '0 && d <= ARR_W'(ARR_DIGIT_MAX)) begin
      g = GAP_W'(1);
      for (int k = 1; k < GAP_MAX; k++) begin
        if (d > ARR_W'(ARR_BIN * k)) begin
          g = GAP_W'(k + 1);
        end
      end
    end
    return g;
  endfunction

  function automatic logic [SVC_W-1:0] service_time(input logic [SVC_DW-1:0] d);
    logic [SVC_W-1:0] s;
    if (d == '0 || d > SVC_B6) s = SVC_W'(0);
    else if (d <= SVC_B1)      s = SVC_W'(1);
    else if (d <= SVC_B2)      s = SVC_W'(2);
    else if (d <= SVC_B3)      s = SVC_W'(3);
    else if (d <= SVC_B4)      s = SVC_W'(4);
    else if (d <= SVC_B5)      s = SVC_W'(5);
    else                       s = SVC_W'(6);
    return s;
  endfunction

  function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] acc,
                                                input logic [TIME_W-1:0] add);
    logic [SUM_W:0] s;
    s = {1'b0, acc} + (SUM_W + 1)'(add);
    return s[SUM_W] ? SUM_MAX : s[SUM_W-1:0];
  endfunction

endpackage

@@ design/ssq_front.sv @@
// Front end: accept customers, map digits to times, queue the work.
module ssq_front import ssq_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      cust_valid,
  output logic      cust_ready,
  input  ssq_cust_t cust,
  output logic      work_valid,
  input  logic      work_take,
  output ssq_work_t work
);

`include "single_server_queue_sim_step_core_macros.svh"

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  ssq_work_t        mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             pop;

  assign cust_ready = (count != CNT_W'(DEPTH));
  assign push       = cust_valid && cust_ready;
  assign work_valid = (count != '0);
  assign pop        = work_valid && work_take;
  assign work       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= '{gap: arrival_gap(cust.arrival_digit),
                       svc: service_time(cust.service_digit)};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  `SSQ_ASSERT_NOW(a_count_bound, clk, rst, 1'b1, count <= CNT_W'(DEPTH), "queue count overrun")
  `SSQ_ASSERT_NEXT(a_count_track, clk, rst, push && !pop, count == $past(count) + CNT_W'(1), "queue count lost a push")

endmodule

@@ design/ssq_back.sv @@
// Back end: advance arrival and server times, update totals, hold the result.
module ssq_back import ssq_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      work_valid,
  output logic      work_take,
  input  ssq_work_t work,
  output logic      rec_valid,
  input  logic      rec_ready,
  output ssq_rec_t  rec
);

`include "single_server_queue_sim_step_core_macros.svh"

  logic [TIME_W-1:0] last_arrival;
  logic [TIME_W-1:0] server_free_at;
  logic [SUM_W-1:0]  acc_service;
  logic [SUM_W-1:0]  acc_wait;
  logic [SUM_W-1:0]  acc_system;
  logic [SUM_W-1:0]  acc_idle;

  logic       s1_valid;
  ssq_times_t s1;

  logic [TIME_W:0]   arrive_sum;
  logic [TIME_W-1:0] arrive;
  logic [TIME_W-1:0] begin_t;
  logic [TIME_W:0]   end_sum;
  logic [TIME_W-1:0] end_t;
  ssq_times_t        s1_next;

  logic [SUM_W-1:0] acc_service_next;
  logic [SUM_W-1:0] acc_wait_next;
  logic [SUM_W-1:0] acc_system_next;
  logic [SUM_W-1:0] acc_idle_next;

  logic out_load;
  logic s1_load;

  assign out_load  = s1_valid && (!rec_valid || rec_ready);
  assign s1_load   = work_valid && (!s1_valid || out_load);
  assign work_take = s1_load;

  always_comb begin
    arrive_sum = {1'b0, last_arrival} + (TIME_W + 1)'(work.gap);
    arrive     = arrive_sum[TIME_W] ? TIME_MAX : arrive_sum[TIME_W-1:0];
    begin_t    = (arrive > server_free_at) ? arrive : server_free_at;
    end_sum    = {1'b0, begin_t} + (TIME_W + 1)'(work.svc);
    end_t      = end_sum[TIME_W] ? TIME_MAX : end_sum[TIME_W-1:0];
    s1_next.interarrival = work.gap;
    s1_next.service_len  = work.svc;
    s1_next.arrive_at    = arrive;
    s1_next.begin_at     = begin_t;
    s1_next.queue_wait   = begin_t - arrive;
    s1_next.end_at       = end_t;
    s1_next.in_system    = end_t - arrive;
    s1_next.server_idle  = begin_t - server_free_at;
  end

  assign acc_service_next = sat_add(acc_service, TIME_W'(s1.service_len));
  assign acc_wait_next    = sat_add(acc_wait, s1.queue_wait);
  assign acc_system_next  = sat_add(acc_system, s1.in_system);
  assign acc_idle_next    = sat_add(acc_idle, s1.server_idle);

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1 <= s1_next;
    end
    if (out_load) begin
      rec <= '{interarrival:  s1.interarrival,
               service_len:   s1.service_len,
               arrive_at:     s1.arrive_at,
               begin_at:      s1.begin_at,
               queue_wait:    s1.queue_wait,
               end_at:        s1.end_at,
               in_system:     s1.in_system,
               server_idle:   s1.server_idle,
               sum_service:   acc_service_next,
               sum_wait:      acc_wait_next,
               sum_in_system: acc_system_next,
               sum_idle:      acc_idle_next};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid       <= 1'b0;
      rec_valid      <= 1'b0;
      last_arrival   <= '0;
      server_free_at <= '0;
      acc_service    <= '0;
      acc_wait       <= '0;
      acc_system     <= '0;
      acc_idle       <= '0;
    end else begin
      if (s1_load) begin
        s1_valid       <= 1'b1;
        last_arrival   <= s1_next.arrive_at;
        server_free_at <= s1_next.end_at;
      end else if (out_load) begin
        s1_valid <= 1'b0;
      end
      if (out_load) begin
        rec_valid   <= 1'b1;
        acc_service <= acc_service_next;
        acc_wait    <= acc_wait_next;
        acc_system  <= acc_system_next;
        acc_idle    <= acc_idle_next;
      end else if (rec_ready) begin
        rec_valid <= 1'b0;
      end
    end
  end

  `SSQ_ASSERT_NOW(a_wait_or_idle, clk, rst, s1_valid, s1.queue_wait == '0 || s1.server_idle == '0, "customer both waited and found server idle")
  `SSQ_ASSERT_NOW(a_time_order, clk, rst, s1_valid, s1.begin_at >= s1.arrive_at && s1.end_at >= s1.begin_at, "service times out of order")
  `SSQ_ASSERT_NEXT(a_s1_hold, clk, rst, s1_valid && !out_load && !s1_load, $stable(s1), "stalled stage changed")
  `SSQ_ASSERT_NEXT(a_wait_total_grows, clk, rst, out_load, acc_wait >= $past(acc_wait), "wait total went down")

endmodule

@@ design/single_server_queue_sim_step_core.sv @@
// A result is held in a queue entry, then in the s1 register, then in the rec register.
// Throughput: one customer per cycle unless the output stalls, set by the back end's arrival and server-free update.
// A queue of DEPTH entries lets the front keep taking customers while the result side stalls.
// Reset (rst, synchronous) clears arrival time, server-free time, totals and all valids.
// Reset needs no clearing pass; the first customer may be taken in the cycle after reset.
module single_server_queue_sim_step_core import ssq_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      cust_valid,
  output logic      cust_ready,
  input  ssq_cust_t cust,
  output logic      rec_valid,
  input  logic      rec_ready,
  output ssq_rec_t  rec
);

  logic      work_valid;
  logic      work_take;
  ssq_work_t work;

  ssq_front #(
    .DEPTH(DEPTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cust_valid (cust_valid),
    .cust_ready (cust_ready),
    .cust       (cust),
    .work_valid (work_valid),
    .work_take  (work_take),
    .work       (work)
  );

  ssq_back u_back (
    .clk        (clk),
    .rst        (rst),
    .work_valid (work_valid),
    .work_take  (work_take),
    .work       (work),
    .rec_valid  (rec_valid),
    .rec_ready  (rec_ready),
    .rec        (rec)
  );

endmodule
